>>> hw/rtl/sm83x_pkg.sv
// Package: types, codes and constants for the opcode 00-3F executor.
`timescale 1ns / 1ps
package sm83x_pkg;
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_t;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_LOAD = 2'd1,
    WAIT_INC  = 2'd2,
    WAIT_DEC  = 2'd3
  } wait_kind_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [15:0] pc;
    wait_kind_t  wk;
    logic [15:0] wa;
  } regs_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  opcode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [7:0]  read_data;
  } item_t;

  // One result; the second write of LD (a16),SP rides in the same record.
  typedef struct packed {
    mem_op_t     op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        two;
    logic [15:0] addr2;
    logic [7:0]  wdata2;
  } req_t;

  localparam logic [3:0] FZ = 4'b1000;
  localparam logic [3:0] FN = 4'b0100;
  localparam logic [3:0] FH = 4'b0010;
  localparam logic [3:0] FC = 4'b0001;
endpackage

>>> hw/rtl/sm83x_exec.sv
// Execute logic: next register state and memory request for one item.
`timescale 1ns / 1ps
module sm83x_exec (
  input  sm83x_pkg::item_t  item,
  input  sm83x_pkg::regs_t  cur,
  output sm83x_pkg::regs_t  nxt,
  output sm83x_pkg::req_t   req
);
  logic [2:0] y, z;
  logic [1:0] p;
  logic       q;
  logic [15:0] hl, pr, pc1, s16, imm;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0] r8, r8n, av;
  logic [3:0] f8;
  logic [8:0] da;
  logic [3:0] dff;
  logic       take, bit_sel;
  logic [1:0] len;

  assign y = item.opcode[5:3];
  assign z = item.opcode[2:0];
  assign p = y[2:1];
  assign q = y[0];
  assign hl = {cur.h, cur.l};
  assign imm = {item.operand_high, item.operand_low};

  always_comb begin
    case (p)
      2'd0: pr = {cur.b, cur.c};
      2'd1: pr = {cur.d, cur.e};
      2'd2: pr = hl;
      default: pr = cur.sp;
    endcase
    case (y)
      3'd0: r8 = cur.b;
      3'd1: r8 = cur.c;
      3'd2: r8 = cur.d;
      3'd3: r8 = cur.e;
      3'd4: r8 = cur.h;
      3'd5: r8 = cur.l;
      3'd7: r8 = cur.a;
      default: r8 = 8'd0;
    endcase
  end

  function automatic logic [11:0] incdec(input logic [7:0] v, input logic dec,
                                         input logic [3:0] f);
    logic [7:0] r;
    logic [3:0] nf;
    r = dec ? v - 8'd1 : v + 8'd1;
    nf = (f & sm83x_pkg::FC) | (dec ? sm83x_pkg::FN : 4'd0);
    if (r == 8'd0) nf = nf | sm83x_pkg::FZ;
    if (dec ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0)) nf = nf | sm83x_pkg::FH;
    return {nf, r};
  endfunction

  always_comb begin
    nxt = cur;
    req = '0;
    req.op = sm83x_pkg::MEM_NONE;
    len = 2'd1;
    take = 1'b0;
    bit_sel = 1'b0;
    sum17 = '0;
    sum13 = '0;
    s16 = '0;
    r8n = '0;
    f8 = '0;
    av = '0;
    da = '0;
    dff = '0;
    pc1 = '0;
    if (item.func) begin
      nxt.wk = sm83x_pkg::WAIT_NONE;
      case (cur.wk)
        sm83x_pkg::WAIT_LOAD: nxt.a = item.read_data;
        sm83x_pkg::WAIT_INC, sm83x_pkg::WAIT_DEC: begin
          {f8, r8n} = incdec(item.read_data, cur.wk == sm83x_pkg::WAIT_DEC, cur.f);
          nxt.f = f8;
          req.op = sm83x_pkg::MEM_WRITE;
          req.addr = cur.wa;
          req.wdata = r8n;
        end
        default: ;
      endcase
    end else if (cur.wk == sm83x_pkg::WAIT_NONE) begin
      if ((z == 3'd1 && !q) || item.opcode == 6'h08) len = 2'd3;
      else if (z == 3'd6 || (z == 3'd0 && y >= 3'd2)) len = 2'd2;
      pc1 = cur.pc + {14'd0, len};
      nxt.pc = pc1;
      case (z)
        3'd0: begin
          if (y == 3'd1) begin
            req.op = sm83x_pkg::MEM_WRITE;
            req.addr = imm;
            req.wdata = cur.sp[7:0];
            req.two = 1'b1;
            req.addr2 = imm + 16'd1;
            req.wdata2 = cur.sp[15:8];
          end else if (y >= 3'd3) begin
            bit_sel = y[1] ? cur.f[0] : cur.f[3];
            take = y[2] ? (y[0] ? bit_sel : !bit_sel) : 1'b1;
            if (take) nxt.pc = pc1 + {{8{item.operand_low[7]}}, item.operand_low};
          end
        end
        3'd1: begin
          if (!q) s16 = imm;
          else begin
            sum17 = {1'b0, hl} + {1'b0, pr};
            sum13 = {1'b0, hl[11:0]} + {1'b0, pr[11:0]};
            nxt.f = (cur.f & sm83x_pkg::FZ) | (sum13[12] ? sm83x_pkg::FH : 4'd0)
                    | (sum17[16] ? sm83x_pkg::FC : 4'd0);
            s16 = sum17[15:0];
          end
          case (q ? 2'd2 : p)
            2'd0: {nxt.b, nxt.c} = s16;
            2'd1: {nxt.d, nxt.e} = s16;
            2'd2: {nxt.h, nxt.l} = s16;
            default: nxt.sp = s16;
          endcase
        end
        3'd2: begin
          req.addr = p[1] ? hl : pr;
          if (p == 2'd2) {nxt.h, nxt.l} = hl + 16'd1;
          if (p == 2'd3) {nxt.h, nxt.l} = hl - 16'd1;
          if (!q) begin
            req.op = sm83x_pkg::MEM_WRITE;
            req.wdata = cur.a;
          end else begin
            req.op = sm83x_pkg::MEM_READ;
            nxt.wk = sm83x_pkg::WAIT_LOAD;
            nxt.wa = req.addr;
          end
        end
        3'd3: begin
          s16 = q ? pr - 16'd1 : pr + 16'd1;
          case (p)
            2'd0: {nxt.b, nxt.c} = s16;
            2'd1: {nxt.d, nxt.e} = s16;
            2'd2: {nxt.h, nxt.l} = s16;
            default: nxt.sp = s16;
          endcase
        end
        3'd4, 3'd5: begin
          if (y == 3'd6) begin
            req.op = sm83x_pkg::MEM_READ;
            req.addr = hl;
            nxt.wk = z[0] ? sm83x_pkg::WAIT_DEC : sm83x_pkg::WAIT_INC;
            nxt.wa = hl;
          end else begin
            {f8, r8n} = incdec(r8, z[0], cur.f);
            nxt.f = f8;
          end
        end
        3'd6: begin
          if (y == 3'd6) begin
            req.op = sm83x_pkg::MEM_WRITE;
            req.addr = hl;
            req.wdata = item.operand_low;
          end else r8n = item.operand_low;
        end
        default: begin
          case (y)
            3'd0: begin
              nxt.a = {cur.a[6:0], cur.a[7]};
              nxt.f = {3'd0, cur.a[7]};
            end
            3'd1: begin
              nxt.a = {cur.a[0], cur.a[7:1]};
              nxt.f = {3'd0, cur.a[0]};
            end
            3'd2: begin
              nxt.a = {cur.a[6:0], cur.f[0]};
              nxt.f = {3'd0, cur.a[7]};
            end
            3'd3: begin
              nxt.a = {cur.f[0], cur.a[7:1]};
              nxt.f = {3'd0, cur.a[0]};
            end
            3'd4: begin
              da = {1'b0, cur.a};
              dff = cur.f;
              if (!cur.f[2]) begin
                if (cur.f[0] || cur.a > 8'h99) begin
                  da = da + 9'h060;
                  dff = dff | sm83x_pkg::FC;
                end
                if (cur.f[1] || da[3:0] > 4'd9) da = da + 9'h006;
              end else begin
                if (cur.f[0]) da = da - 9'h060;
                if (cur.f[1]) da = da - 9'h006;
              end
              av = da[7:0];
              nxt.a = av;
              nxt.f = (dff & (sm83x_pkg::FN | sm83x_pkg::FC))
                      | ((av == 8'd0) ? sm83x_pkg::FZ : 4'd0);
            end
            3'd5: begin
              nxt.a = ~cur.a;
              nxt.f = cur.f | sm83x_pkg::FN | sm83x_pkg::FH;
            end
            3'd6: nxt.f = (cur.f & sm83x_pkg::FZ) | sm83x_pkg::FC;
            default: nxt.f = (cur.f & sm83x_pkg::FZ) | {3'd0, ~cur.f[0]};
          endcase
        end
      endcase
      if ((z == 3'd4 || z == 3'd5 || z == 3'd6) && y != 3'd6) begin
        case (y)
          3'd0: nxt.b = r8n;
          3'd1: nxt.c = r8n;
          3'd2: nxt.d = r8n;
          3'd3: nxt.e = r8n;
          3'd4: nxt.h = r8n;
          3'd5: nxt.l = r8n;
          3'd7: nxt.a = r8n;
          default: ;
        endcase
      end
    end
  end
endmodule

>>> hw/rtl/cpu_opcode_block_00_3f_executor_core.sv
// Top level: register file, result register with second-write slot.
`timescale 1ns / 1ps
// channel | dir | fields (tdata low bit up)
// s_axis  | in  | tuser=func; tdata=opcode[5:0] operand_low[13:6] operand_high[21:14]
//         |     |   read_data[29:22], zero fill to 32
// m_axis  | out | tdata=mem_op[1:0] mem_addr[17:2] mem_wdata[25:18] pair_af[41:26]
//         |     |   pair_bc[57:42] pair_de[73:58] pair_hl[89:74] stack_value[105:90]
//         |     |   pc_value[121:106] awaiting_reply[122], zero fill; tlast=last
// Unless stalled, one item is accepted per cycle; its result is out the cycle after.
// LD (a16),SP gives two results; the second follows once the first is taken.
// Reset clears the CPU registers, the output data and the output valid.
// Input stalls while the output holds an untaken result or a second write is pending.
module cpu_opcode_block_00_3f_executor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode, operand_low, operand_high, read_data
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata, // mem_op .. awaiting_reply, see table
  output logic        m_axis_tlast
);
  sm83x_pkg::regs_t regs, regs_next;
  sm83x_pkg::item_t item;
  sm83x_pkg::req_t  req;
  logic       pend;
  logic [15:0] pend_addr;
  logic [7:0]  pend_wdata;
  logic        xfer_in;

  assign item.func         = s_axis_tuser;
  assign item.opcode       = s_axis_tdata[5:0];
  assign item.operand_low  = s_axis_tdata[13:6];
  assign item.operand_high = s_axis_tdata[21:14];
  assign item.read_data    = s_axis_tdata[29:22];

  sm83x_exec u_exec (.item(item), .cur(regs), .nxt(regs_next), .req(req));

  assign s_axis_tready = !pend && (!m_axis_tvalid || m_axis_tready);
  assign xfer_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
    end else if (pend) begin
      if (m_axis_tready) begin
        m_axis_tdata[17:2] <= pend_addr;
        m_axis_tdata[25:18] <= pend_wdata;
        m_axis_tlast <= 1'b1;
        pend <= 1'b0;
      end
    end else if (xfer_in) begin
      regs <= regs_next;
      m_axis_tvalid <= 1'b1;
      m_axis_tlast <= !req.two;
      pend <= req.two;
      pend_addr <= req.addr2;
      pend_wdata <= req.wdata2;
      m_axis_tdata <= {5'd0, (regs_next.wk != sm83x_pkg::WAIT_NONE), regs_next.pc,
                       regs_next.sp, regs_next.h, regs_next.l, regs_next.d, regs_next.e,
                       regs_next.b, regs_next.c, regs_next.a, regs_next.f, 4'd0,
                       req.wdata, req.addr, req.op};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
endmodule

>>> hw/rtl/sm83x_checker.sv
// Checker: port-level properties of the executor, bound to the top level.
`timescale 1ns / 1ps
module sm83x_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("output changed under stall");
  a_in_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");
  a_second: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast
      && m_axis_tdata[1:0] == sm83x_pkg::MEM_WRITE)
    else $error("second write missing");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken between paired writes");
endmodule

bind cpu_opcode_block_00_3f_executor_core sm83x_checker u_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));

>>> tb/sv/cpu_opcode_block_00_3f_executor_core_test.sv
// Self-checking stream testbench for the opcode 00-3F executor core.
`timescale 1ns / 1ps
module cpu_opcode_block_00_3f_executor_core_test;
  typedef struct packed {
    sm83x_pkg::mem_op_t op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic        busy;
    logic        last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic m_axis_tlast;

  cpu_opcode_block_00_3f_executor_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sm83x_pkg::item_t pending_items[$];
  outcome_t expected_outcomes[$];
  sm83x_pkg::regs_t cpu;
  int errors = 0;
  int gap = 0;
  int rgap = 0;
  bit hold_send = 1'b0;
  bit sending = 1'b0;
  bit accepted = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pair_get(int p);
    case (p)
      0: return {cpu.b, cpu.c};
      1: return {cpu.d, cpu.e};
      2: return {cpu.h, cpu.l};
      default: return cpu.sp;
    endcase
  endfunction

  function automatic void pair_set(int p, logic [15:0] v);
    case (p)
      0: {cpu.b, cpu.c} = v;
      1: {cpu.d, cpu.e} = v;
      2: {cpu.h, cpu.l} = v;
      default: cpu.sp = v;
    endcase
  endfunction

  function automatic logic [7:0] r8_get(int r);
    case (r)
      0: return cpu.b;
      1: return cpu.c;
      2: return cpu.d;
      3: return cpu.e;
      4: return cpu.h;
      5: return cpu.l;
      7: return cpu.a;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void r8_set(int r, logic [7:0] v);
    case (r)
      0: cpu.b = v;
      1: cpu.c = v;
      2: cpu.d = v;
      3: cpu.e = v;
      4: cpu.h = v;
      5: cpu.l = v;
      7: cpu.a = v;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] bump8(logic [7:0] v, bit down);
    logic [7:0] r;
    r = down ? v - 8'd1 : v + 8'd1;
    cpu.f = (cpu.f & sm83x_pkg::FC) | (r == 8'h00 ? sm83x_pkg::FZ : 4'h0)
            | (down ? sm83x_pkg::FN : 4'h0);
    if (down ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0)) cpu.f |= sm83x_pkg::FH;
    return r;
  endfunction

  function automatic void log_outcome(sm83x_pkg::mem_op_t op, logic [15:0] addr,
                                      logic [7:0] wd, logic last);
    outcome_t o;
    o.op = op;
    o.addr = addr;
    o.wdata = wd;
    o.af = {cpu.a, cpu.f, 4'h0};
    o.bc = pair_get(0);
    o.de = pair_get(1);
    o.hl = pair_get(2);
    o.sp = cpu.sp;
    o.pc = cpu.pc;
    o.busy = (cpu.wk != sm83x_pkg::WAIT_NONE);
    o.last = last;
    expected_outcomes.push_back(o);
  endfunction

  function automatic void execute_item(sm83x_pkg::item_t it);
    int y, z, p, q;
    logic [15:0] hl, addr, a16;
    logic [16:0] sum;
    logic [8:0] acc9;
    logic [7:0] v;
    logic [3:0] f;
    sm83x_pkg::wait_kind_t k;
    bit take, bitv, nc;
    y = int'(it.opcode[5:3]);
    z = int'(it.opcode[2:0]);
    p = y >> 1;
    q = y & 1;
    if (it.func) begin
      k = cpu.wk;
      cpu.wk = sm83x_pkg::WAIT_NONE;
      if (k == sm83x_pkg::WAIT_LOAD) cpu.a = it.read_data;
      if (k == sm83x_pkg::WAIT_NONE || k == sm83x_pkg::WAIT_LOAD) begin
        log_outcome(sm83x_pkg::MEM_NONE, 16'h0, 8'h0, 1'b1);
      end else begin
        v = bump8(it.read_data, k == sm83x_pkg::WAIT_DEC);
        log_outcome(sm83x_pkg::MEM_WRITE, cpu.wa, v, 1'b1);
      end
      return;
    end
    if (cpu.wk != sm83x_pkg::WAIT_NONE) begin
      log_outcome(sm83x_pkg::MEM_NONE, 16'h0, 8'h0, 1'b1);
      return;
    end
    if ((z == 1 && q == 0) || it.opcode == 6'h08) cpu.pc += 16'd3;
    else if (z == 6 || (z == 0 && y >= 2)) cpu.pc += 16'd2;
    else cpu.pc += 16'd1;
    hl = pair_get(2);
    case (z)
      0: begin
        if (y == 1) begin
          a16 = {it.operand_high, it.operand_low};
          log_outcome(sm83x_pkg::MEM_WRITE, a16, cpu.sp[7:0], 1'b0);
          log_outcome(sm83x_pkg::MEM_WRITE, a16 + 16'd1, cpu.sp[15:8], 1'b1);
          return;
        end
        if (y >= 3) begin
          take = 1'b1;
          if (y >= 4) begin
            bitv = (y < 6) ? cpu.f[3] : cpu.f[0];
            take = (y & 1) ? bitv : !bitv;
          end
          if (take) cpu.pc += {{8{it.operand_low[7]}}, it.operand_low};
        end
      end
      1: begin
        if (q == 0) begin
          pair_set(p, {it.operand_high, it.operand_low});
        end else begin
          sum = {1'b0, hl} + {1'b0, pair_get(p)};
          f = cpu.f & sm83x_pkg::FZ;
          if ({1'b0, hl[11:0]} + {1'b0, pair_get(p) & 16'h0FFF} > 13'h0FFF)
            f |= sm83x_pkg::FH;
          if (sum[16]) f |= sm83x_pkg::FC;
          cpu.f = f;
          pair_set(2, sum[15:0]);
        end
      end
      2: begin
        addr = (p < 2) ? pair_get(p) : hl;
        if (p == 2) pair_set(2, hl + 16'd1);
        if (p == 3) pair_set(2, hl - 16'd1);
        if (q == 0) begin
          log_outcome(sm83x_pkg::MEM_WRITE, addr, cpu.a, 1'b1);
        end else begin
          cpu.wk = sm83x_pkg::WAIT_LOAD;
          cpu.wa = addr;
          log_outcome(sm83x_pkg::MEM_READ, addr, 8'h0, 1'b1);
        end
        return;
      end
      3: pair_set(p, q ? pair_get(p) - 16'd1 : pair_get(p) + 16'd1);
      4, 5: begin
        if (y == 6) begin
          cpu.wk = (z == 4) ? sm83x_pkg::WAIT_INC : sm83x_pkg::WAIT_DEC;
          cpu.wa = hl;
          log_outcome(sm83x_pkg::MEM_READ, hl, 8'h0, 1'b1);
          return;
        end
        r8_set(y, bump8(r8_get(y), z == 5));
      end
      6: begin
        if (y == 6) begin
          log_outcome(sm83x_pkg::MEM_WRITE, hl, it.operand_low, 1'b1);
          return;
        end
        r8_set(y, it.operand_low);
      end
      default: begin
        case (y)
          0: begin
            nc = cpu.a[7]; cpu.a = {cpu.a[6:0], nc}; cpu.f = nc ? sm83x_pkg::FC : 4'h0;
          end
          1: begin
            nc = cpu.a[0]; cpu.a = {nc, cpu.a[7:1]}; cpu.f = nc ? sm83x_pkg::FC : 4'h0;
          end
          2: begin
            nc = cpu.a[7]; cpu.a = {cpu.a[6:0], cpu.f[0]};
            cpu.f = nc ? sm83x_pkg::FC : 4'h0;
          end
          3: begin
            nc = cpu.a[0]; cpu.a = {cpu.f[0], cpu.a[7:1]};
            cpu.f = nc ? sm83x_pkg::FC : 4'h0;
          end
          4: begin
            acc9 = {1'b0, cpu.a};
            f = cpu.f;
            if (!f[2]) begin
              if (f[0] || acc9 > 9'h099) begin acc9 += 9'h060; f |= sm83x_pkg::FC; end
              if (f[1] || acc9[3:0] > 4'd9) acc9 += 9'h006;
            end else begin
              if (f[0]) acc9 -= 9'h060;
              if (f[1]) acc9 -= 9'h006;
            end
            cpu.a = acc9[7:0];
            cpu.f = (f & (sm83x_pkg::FN | sm83x_pkg::FC))
                    | (cpu.a == 8'h00 ? sm83x_pkg::FZ : 4'h0);
          end
          5: begin cpu.a = ~cpu.a; cpu.f |= sm83x_pkg::FN | sm83x_pkg::FH; end
          6: cpu.f = (cpu.f & sm83x_pkg::FZ) | sm83x_pkg::FC;
          default: cpu.f = (cpu.f & sm83x_pkg::FZ) | ((cpu.f & sm83x_pkg::FC) ^ sm83x_pkg::FC);
        endcase
      end
    endcase
    log_outcome(sm83x_pkg::MEM_NONE, 16'h0, 8'h0, 1'b1);
  endfunction

  function automatic sm83x_pkg::item_t make_item(bit func, logic [5:0] opc);
    sm83x_pkg::item_t it;
    it.func = func;
    it.opcode = opc;
    it.operand_low = 8'($urandom_range(0, 255));
    it.operand_high = 8'($urandom_range(0, 255));
    it.read_data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic bit needs_reply(logic [5:0] opc);
    return opc == 6'h0A || opc == 6'h1A || opc == 6'h2A || opc == 6'h3A ||
           opc == 6'h34 || opc == 6'h35;
  endfunction

  always @(posedge clk) begin
    accepted <= s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!(s_axis_tvalid && !accepted)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_axis_tvalid <= 1'b0;
          sending <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_send) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, pending_items[0].read_data, pending_items[0].operand_high,
                           pending_items[0].operand_low, pending_items[0].opcode};
          s_axis_tuser <= pending_items[0].func;
          execute_item(pending_items.pop_front());
          sending <= 1'b1;
          gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
          sending <= 1'b0;
        end
      end
      if (rgap > 0) begin
        rgap <= rgap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0) rgap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.op = sm83x_pkg::mem_op_t'(m_axis_tdata[1:0]);
      got.addr = m_axis_tdata[17:2];
      got.wdata = m_axis_tdata[25:18];
      got.af = m_axis_tdata[41:26];
      got.bc = m_axis_tdata[57:42];
      got.de = m_axis_tdata[73:58];
      got.hl = m_axis_tdata[89:74];
      got.sp = m_axis_tdata[105:90];
      got.pc = m_axis_tdata[121:106];
      got.busy = m_axis_tdata[122];
      got.last = m_axis_tlast;
      if (expected_outcomes.size() == 0) begin
        $error("unexpected transfer");
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.op != want.op) begin $error("mem_op exp %0d got %0d", want.op, got.op); errors++; end
        if (got.addr != want.addr) begin $error("mem_addr exp %h got %h", want.addr, got.addr); errors++; end
        if (got.wdata != want.wdata) begin $error("mem_wdata exp %h got %h", want.wdata, got.wdata); errors++; end
        if (got.af != want.af) begin $error("pair_af exp %h got %h", want.af, got.af); errors++; end
        if (got.bc != want.bc) begin $error("pair_bc exp %h got %h", want.bc, got.bc); errors++; end
        if (got.de != want.de) begin $error("pair_de exp %h got %h", want.de, got.de); errors++; end
        if (got.hl != want.hl) begin $error("pair_hl exp %h got %h", want.hl, got.hl); errors++; end
        if (got.sp != want.sp) begin $error("stack_value exp %h got %h", want.sp, got.sp); errors++; end
        if (got.pc != want.pc) begin $error("pc_value exp %h got %h", want.pc, got.pc); errors++; end
        if (got.busy != want.busy) begin
          $error("awaiting_reply exp %0d got %0d", want.busy, got.busy); errors++;
        end
        if (got.last != want.last) begin $error("last exp %0d got %0d", want.last, got.last); errors++; end
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sm83x_pkg::item_t it;
    logic [5:0] opc;
    cpu = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes and special cases
    it = '{1'b0, 6'h01, 8'hFF, 8'hFF, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h31, 8'hFF, 8'hFF, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h08, 8'hFF, 8'hFF, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h09, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h3E, 8'h99, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h27, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h2F, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h37, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h3F, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h18, 8'h80, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h38, 8'h7F, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h10, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h00, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b1, 6'h3F, 8'hFF, 8'hFF, 8'hFF}; pending_items.push_back(it);
    it = '{1'b0, 6'h34, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h3C, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b1, 6'h00, 8'h00, 8'h00, 8'hFF}; pending_items.push_back(it);
    it = '{1'b0, 6'h35, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b1, 6'h00, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h2A, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b1, 6'h00, 8'h00, 8'h00, 8'hA5}; pending_items.push_back(it);
    it = '{1'b0, 6'h36, 8'h5A, 8'h00, 8'h00}; pending_items.push_back(it);
    it = '{1'b0, 6'h22, 8'h00, 8'h00, 8'h00}; pending_items.push_back(it);
    // random: read requests are always answered, sometimes the reply is late
    for (int n = 0; n < 650; n++) begin
      if (n == 300) begin
        wait (pending_items.size() == 0 && !sending);
        hold_send = 1'b1;
        wait (expected_outcomes.size() == 0);
        hold_send = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) begin
        pending_items.push_back(make_item(1'b1, 6'($urandom_range(0, 63))));
      end else begin
        opc = 6'($urandom_range(0, 63));
        pending_items.push_back(make_item(1'b0, opc));
        if (needs_reply(opc)) begin
          if ($urandom_range(0, 5) == 0) begin
            n++;
            pending_items.push_back(make_item(1'b0, 6'($urandom_range(0, 63))));
          end
          n++;
          pending_items.push_back(make_item(1'b1, 6'($urandom_range(0, 63))));
        end
      end
    end
    wait (pending_items.size() == 0 && !sending && expected_outcomes.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
